// ===== hw/rtl/kset_pkg.sv =====
// Shared types, constants and character codes of the key sequence escape translator.
`default_nettype none

package kset_pkg;

	// Depth of the burst queue between front and back, in bursts.
	localparam int KSET_QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERT_META = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_PREFIX   = 2'd1;

	// Key codes produced by escapes.
	localparam logic [7:0] KEY_BEL    = 8'h07;
	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_TAB    = 8'h09;
	localparam logic [7:0] KEY_LF     = 8'h0A;
	localparam logic [7:0] KEY_VT     = 8'h0B;
	localparam logic [7:0] KEY_FF     = 8'h0C;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_ESC    = 8'h1B;
	localparam logic [7:0] KEY_FS     = 8'h1C;
	localparam logic [7:0] KEY_RUBOUT = 8'h7F;
	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_META   = 8'h80;
	localparam logic [7:0] KEY_META_FS = 8'hDC;

	// Characters of the binding text that steer the escape parser.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_UP_C   = 8'h43;
	localparam logic [7:0] CH_UP_M   = 8'h4D;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_D   = 8'h64;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_V   = 8'h76;
	localparam logic [7:0] CH_LO_X   = 8'h78;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_7  = 8'h37;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;

	// Escape parser phase.
	typedef enum logic [3:0] {
		PH_PLAIN     = 4'd0,
		PH_BS        = 4'd1,
		PH_BS_C      = 4'd2,
		PH_BS_M      = 4'd3,
		PH_CD        = 4'd4,
		PH_CD_BS     = 4'd5,
		PH_CD_BS_M   = 4'd6,
		PH_CD_BS_MD  = 4'd7,
		PH_MD        = 4'd8,
		PH_MD_BS     = 4'd9,
		PH_MD_BS_C   = 4'd10,
		PH_MD_BS_CD  = 4'd11,
		PH_OCT       = 4'd12,
		PH_HEX       = 4'd13
	} kset_phase_t;

	// Configuration as seen by the front part.
	typedef struct packed {
		logic convert_meta;
		logic esc_is_prefix_map;
	} kset_cfg_t;

	// The key bytes caused by one input character.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            last;
	} kset_burst_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kset_front.sv =====
// Front part: accepts text characters, runs the escape parser and forms key bursts.
`default_nettype none

module kset_front
	import kset_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        text_last,
	input  wire kset_cfg_t   cfg,
	input  wire logic        q_full,
	output logic             push,
	output kset_burst_t      push_burst
);

	kset_phase_t phase_q, phase_n;
	logic [7:0]  value_q, value_n;
	logic [1:0]  digits_q, digits_n;
	kset_burst_t burst;
	logic        accept;
	logic [7:0]  ch;
	logic [7:0]  ctrl_ch;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic        oct_ok;

	// Append one byte to a burst; bytes past the third are dropped.
	function automatic kset_burst_t put(kset_burst_t b, logic [7:0] v);
		kset_burst_t r;
		r = b;
		if (r.count != 2'd3) begin
			r.bytes[r.count] = v;
			r.count = r.count + 2'd1;
		end
		return r;
	endfunction

	// True where the phase gives the character back as ordinary text.
	function automatic logic hands_back(kset_phase_t ph, logic [7:0] c, logic hok, logic ook);
		logic r;
		r = 1'b0;
		case (ph)
			PH_PLAIN:    r = 1'b1;
			PH_BS_C:     r = (c != CH_DASH);
			PH_BS_M:     r = (c != CH_DASH);
			PH_CD_BS:    r = (c != CH_UP_M);
			PH_CD_BS_M:  r = (c != CH_DASH);
			PH_MD_BS:    r = (c != CH_UP_C);
			PH_MD_BS_C:  r = (c != CH_DASH);
			PH_OCT:      r = !ook;
			PH_HEX:      r = !hok;
			PH_BS, PH_CD, PH_CD_BS_MD, PH_MD, PH_MD_BS_CD: r = 1'b0;
			default:     r = 1'b1;
		endcase
		return r;
	endfunction

	assign ch = text_byte;
	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// Control code of the character: uppercase first, then keep five bits.
	always_comb begin
		if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
			ctrl_ch = {3'b000, ch[4:0]};
		end else begin
			ctrl_ch = {3'b000, ch[4:0]};
		end
	end

	// Digit decoding for octal and hex escapes.
	always_comb begin
		oct_ok = ch inside {[CH_DIG_0:CH_DIG_7]};
		hex_ok = 1'b1;
		hex_val = ch[3:0];
		if (ch inside {[CH_DIG_0:CH_DIG_9]}) begin
			hex_val = ch[3:0];
		end else if (ch inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]}) begin
			hex_val = ch[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Phase state and digit accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			value_q  <= '0;
			digits_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			value_q  <= value_n;
			digits_q <= digits_n;
		end
	end

	// Next phase and the bytes this character releases.
	always_comb begin
		burst    = '0;
		phase_n  = phase_q;
		value_n  = value_q;
		digits_n = digits_q;
		case (phase_q)
			PH_BS: begin
				phase_n = PH_PLAIN;
				case (ch)
					CH_LO_A:   burst = put(burst, KEY_BEL);
					CH_LO_B:   burst = put(burst, KEY_BS);
					CH_LO_D:   burst = put(burst, KEY_RUBOUT);
					CH_LO_E:   burst = put(burst, KEY_ESC);
					CH_LO_F:   burst = put(burst, KEY_FF);
					CH_LO_N:   burst = put(burst, KEY_LF);
					CH_LO_R:   burst = put(burst, KEY_CR);
					CH_LO_T:   burst = put(burst, KEY_TAB);
					CH_LO_V:   burst = put(burst, KEY_VT);
					CH_BSLASH: burst = put(burst, CH_BSLASH);
					CH_UP_C:   phase_n = PH_BS_C;
					CH_UP_M:   phase_n = PH_BS_M;
					CH_LO_X: begin
						phase_n  = PH_HEX;
						value_n  = '0;
						digits_n = '0;
					end
					default: begin
						if (oct_ok) begin
							phase_n  = PH_OCT;
							value_n  = {5'b00000, ch[2:0]};
							digits_n = 2'd1;
						end else begin
							burst = put(burst, ch);
						end
					end
				endcase
			end
			PH_BS_C: begin
				if (ch == CH_DASH) begin
					phase_n = PH_CD;
				end else begin
					burst = put(burst, CH_UP_C);
					phase_n = PH_PLAIN;
				end
			end
			PH_BS_M: begin
				if (ch == CH_DASH) begin
					if (cfg.convert_meta && cfg.esc_is_prefix_map) begin
						burst = put(burst, KEY_ESC);
						phase_n = PH_PLAIN;
					end else begin
						phase_n = PH_MD;
					end
				end else begin
					burst = put(burst, CH_UP_M);
					phase_n = PH_PLAIN;
				end
			end
			PH_CD: begin
				phase_n = PH_PLAIN;
				if (ch == CH_BSLASH) begin
					phase_n = PH_CD_BS;
				end else begin
					burst = put(burst, (ch == CH_QMARK) ? KEY_RUBOUT : ctrl_ch);
				end
			end
			PH_CD_BS: begin
				if (ch == CH_UP_M) begin
					phase_n = PH_CD_BS_M;
				end else begin
					burst = put(burst, KEY_FS);
					phase_n = PH_PLAIN;
				end
			end
			PH_CD_BS_M: begin
				if (ch == CH_DASH) begin
					phase_n = PH_CD_BS_MD;
				end else begin
					burst = put(burst, KEY_FS);
					burst = put(burst, CH_UP_M);
					phase_n = PH_PLAIN;
				end
			end
			PH_CD_BS_MD: begin
				burst = put(burst, KEY_ESC);
				burst = put(burst, ctrl_ch);
				phase_n = PH_PLAIN;
			end
			PH_MD: begin
				phase_n = PH_PLAIN;
				if (ch == CH_BSLASH) begin
					phase_n = PH_MD_BS;
				end else begin
					burst = put(burst, ch | KEY_META);
				end
			end
			PH_MD_BS: begin
				if (ch == CH_UP_C) begin
					phase_n = PH_MD_BS_C;
				end else begin
					burst = put(burst, KEY_META_FS);
					phase_n = PH_PLAIN;
				end
			end
			PH_MD_BS_C: begin
				if (ch == CH_DASH) begin
					phase_n = PH_MD_BS_CD;
				end else begin
					burst = put(burst, KEY_META_FS);
					burst = put(burst, CH_UP_C);
					phase_n = PH_PLAIN;
				end
			end
			PH_MD_BS_CD: begin
				burst = put(burst, ((ch == CH_QMARK) ? KEY_RUBOUT : ctrl_ch) | KEY_META);
				phase_n = PH_PLAIN;
			end
			PH_OCT: begin
				if (oct_ok) begin
					value_n  = {value_q[4:0], ch[2:0]};
					digits_n = digits_q + 2'd1;
					if (digits_n == 2'd3) begin
						burst = put(burst, value_n);
						phase_n = PH_PLAIN;
					end
				end else begin
					burst = put(burst, value_q);
					phase_n = PH_PLAIN;
				end
			end
			PH_HEX: begin
				if (hex_ok) begin
					value_n  = {value_q[3:0], hex_val};
					digits_n = digits_q + 2'd1;
					if (digits_n >= 2'd2) begin
						burst = put(burst, value_n);
						phase_n = PH_PLAIN;
					end
				end else begin
					burst = put(burst, (digits_q != 2'd0) ? value_q : CH_LO_X);
					phase_n = PH_PLAIN;
				end
			end
			default: begin
				phase_n = PH_PLAIN;
			end
		endcase

		// A broken prefix hands the character back to plain text handling.
		if (phase_n == PH_PLAIN && hands_back(phase_q, ch, hex_ok, oct_ok)) begin
			if (ch == CH_BSLASH) begin
				phase_n = PH_BS;
			end else begin
				burst = put(burst, ch);
			end
		end

		// End of text: flush whatever escape is still pending.
		if (text_last) begin
			case (phase_n)
				PH_BS:       burst = put(burst, CH_BSLASH);
				PH_BS_C:     burst = put(burst, CH_UP_C);
				PH_BS_M:     burst = put(burst, CH_UP_M);
				PH_CD:       burst = put(burst, KEY_NUL);
				PH_CD_BS:    burst = put(burst, KEY_FS);
				PH_CD_BS_M: begin
					burst = put(burst, KEY_FS);
					burst = put(burst, CH_UP_M);
				end
				PH_CD_BS_MD: begin
					burst = put(burst, KEY_ESC);
					burst = put(burst, KEY_NUL);
				end
				PH_MD:       burst = put(burst, KEY_META);
				PH_MD_BS:    burst = put(burst, KEY_META_FS);
				PH_MD_BS_C: begin
					burst = put(burst, KEY_META_FS);
					burst = put(burst, CH_UP_C);
				end
				PH_MD_BS_CD: burst = put(burst, KEY_META);
				PH_OCT:      burst = put(burst, value_n);
				PH_HEX:      burst = put(burst, (digits_n != 2'd0) ? value_n : CH_LO_X);
				default: ;
			endcase
			phase_n  = PH_PLAIN;
			value_n  = '0;
			digits_n = '0;
		end
		burst.last = text_last;
	end

	assign push       = accept && (burst.count != 2'd0);
	assign push_burst = burst;

endmodule

`default_nettype wire

// ===== hw/rtl/kset_queue.sv =====
// Burst queue that decouples the escape parser from the output sequencer.
`default_nettype none

module kset_queue
	import kset_pkg::*;
#(
	parameter int QUEUE_DEPTH = KSET_QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire kset_burst_t  push_burst,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output kset_burst_t       head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	kset_burst_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [LW-1:0]       level_q;

	assign full       = (level_q == LW'(QUEUE_DEPTH));
	assign head_valid = (level_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Storage: written at the tail, no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_burst;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/kset_back.sv =====
// Back part: walks each queued burst and presents one key byte per transaction.
`default_nettype none

module kset_back
	import kset_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire kset_burst_t  head,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        key_byte,
	output logic              run_last,
	output logic              sequence_end
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] key_byte_q;
	logic       run_last_q;
	logic       seq_end_q;
	logic       slot_free;
	logic       load;
	logic       is_final;

	// The output register frees up when empty or when its transaction completes.
	assign slot_free = !out_valid_q || !out_stall;
	assign load      = slot_free && head_valid;
	assign is_final  = (idx_q == (head.count - 2'd1));
	assign pop       = load && is_final;

	// Byte position within the current burst and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_final ? 2'd0 : idx_q + 2'd1;
			end
			if (slot_free) begin
				out_valid_q <= head_valid;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			key_byte_q <= head.bytes[idx_q];
			run_last_q <= is_final;
			seq_end_q  <= is_final && head.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign key_byte     = key_byte_q;
	assign run_last     = run_last_q;
	assign sequence_end = seq_end_q;

endmodule

`default_nettype wire

// ===== hw/rtl/key_sequence_escape_translator_core.sv =====
// Top level of the key sequence escape translator.
`default_nettype none

// Translates key-binding text, one character per input transaction, into key bytes,
// one byte per output transaction. The parser at the front takes a character every
// cycle unless the queue is full and turns it into a burst of zero to three key bytes;
// a queue of QUEUE_DEPTH bursts feeds the output sequencer, which sends one byte per
// cycle unless the output stalls. Characters that give at most one byte therefore
// flow at one per cycle; a character that gives more bytes holds the output until all
// are sent, and input stalls once the queue is full. A byte passes through a queue
// entry and the output register. The configuration registers take a write in any
// cycle (ready is always high) and should be changed only while the block is idle.

module key_sequence_escape_translator_core
	import kset_pkg::*;
#(
	parameter int QUEUE_DEPTH = KSET_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 text_last,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                key_byte,
	output logic                      run_last,
	output logic                      sequence_end
);

	kset_cfg_t   cfg_q;
	logic        q_full;
	logic        push;
	kset_burst_t push_burst;
	logic        pop;
	logic        head_valid;
	kset_burst_t head;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.convert_meta      <= 1'b1;
			cfg_q.esc_is_prefix_map <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CONVERT_META: cfg_q.convert_meta      <= cfg_data;
				REG_ESC_PREFIX:   cfg_q.esc_is_prefix_map <= cfg_data;
				default: ;
			endcase
		end
	end

	kset_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.text_last  (text_last),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.push_burst (push_burst)
	);

	kset_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_burst (push_burst),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	kset_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_byte     (key_byte),
		.run_last     (run_last),
		.sequence_end (sequence_end)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/kset_checker.sv =====
// Port-level checker for the key sequence escape translator, bound to the top level.
`default_nettype none

module kset_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] key_byte,
	input wire logic       run_last,
	input wire logic       sequence_end
);

	// A stalled result transaction keeps its valid and payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_byte)
			&& $stable(run_last) && $stable(sequence_end))
		else $error("stalled output transaction changed");

	// The end of a sequence is always the last byte of its character.
	a_seq_end_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_end |-> run_last)
		else $error("sequence end without run last");

	// Input only stalls when the queue is full, which means a result is on offer.
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output pending");

endmodule

bind key_sequence_escape_translator_core kset_checker u_kset_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.key_byte     (key_byte),
	.run_last     (run_last),
	.sequence_end (sequence_end)
);

`default_nettype wire
